>>> sv/iaie_pkg.sv
package iaie_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = AW + 1;
	localparam int PAW = 3;

	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_POP = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_INSERT = 3'd4;
	localparam logic [2:0] OP_ERASE = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [0:0] REG_CAPACITY_LIMIT = 1'b0;
	localparam logic [6:0] CAP_RESET = 7'(CAPACITY);

endpackage

>>> sv/indexed_array_insert_erase_top.sv
// Bounded ordered list of signed 32-bit words with push, pop, read, write,
// insert and erase.
// A request is taken at a rising edge where start is high and busy is low.
// Its result appears on status, read_value, count, is_empty and is_full,
// marked by done for exactly one cycle; the receiver cannot stall the block.
// Push, pop, write, unused opcodes, rejected requests, an insert at the end
// and an erase at the last index end without a shift: done rises in the
// cycle after the item is taken. A read waits in S_RDWAIT for the RAM data.
// Insert and erase move the later elements through the single element RAM,
// one read and one write per cycle. An insert at index i copies each element
// from i onward up by one place, last one first, then writes the new word at
// i in S_FINAL; an erase copies each element after i down by one place. The
// RAM has one write port.
// busy stays high until done is raised; a new item may be taken while done
// is shown.
// The capacity limit register sits at every APB address with paddr[2] low;
// the user must write it only while the block is idle (not enforced). Reset
// clears the count and sets the limit to 64; unwritten words are undefined.
module indexed_array_insert_erase_top
	import iaie_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [2:0]             opcode,
	input  logic [6:0]             index,
	input  logic signed [31:0]     write_value,
	output logic                   done,
	output logic [1:0]             status,
	output logic signed [31:0]     read_value,
	output logic [6:0]             count,
	output logic                   is_empty,
	output logic                   is_full,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PAW-1:0]         paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SHIFT = 2'd1;
	localparam logic [1:0] S_RDWAIT = 2'd2;
	localparam logic [1:0] S_FINAL = 2'd3;

	logic [31:0] mem [CAPACITY];
	logic [31:0] rdata_q;

	logic [1:0] state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [6:0] cap_q;
	logic done_q, done_d;

	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] wa_q, wa_d;
	logic [AW-1:0] n_q, n_d;
	logic up_q, up_d;
	logic [AW-1:0] idx_q;
	logic [31:0] val_q;
	logic load;

	logic [1:0] res_status_q, res_status_d;
	logic [31:0] res_rd_q;
	logic [CW-1:0] res_count_q;
	logic res_empty_q, res_full_q;

	logic we, re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	logic [CW-1:0] lim;
	logic [CW-1:0] cnt_m1, cnt_m2, idx_p1, idx_p2, ins_n, ers_n;
	logic cfg_we;

	always_comb begin
		if (cap_q == 7'd0) begin
			lim = CW'(1);
		end else if (cap_q > 7'(CAPACITY)) begin
			lim = CW'(CAPACITY);
		end else begin
			lim = CW'(cap_q);
		end
	end

	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign idx_p1 = index + CW'(1);
	assign idx_p2 = index + CW'(2);
	assign ins_n = count_q - CW'(1) - index;
	assign ers_n = count_q - CW'(2) - index;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		done_d = 1'b0;
		ptr_d = ptr_q;
		wa_d = wa_q;
		n_d = n_q;
		up_d = up_q;
		res_status_d = ST_OK;
		load = 1'b0;
		we = 1'b0;
		mem_wa = wa_q;
		mem_wd = rdata_q;
		re = 1'b0;
		mem_ra = ptr_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					load = 1'b1;
					done_d = 1'b1;
					mem_wd = write_value;
					case (opcode)
						OP_PUSH: begin
							if (count_q >= lim) begin
								res_status_d = ST_FULL;
							end else begin
								we = 1'b1;
								mem_wa = count_q[AW-1:0];
								count_d = count_q + CW'(1);
							end
						end
						OP_POP: begin
							if (count_q == '0) begin
								res_status_d = ST_EMPTY;
							end else begin
								count_d = cnt_m1;
							end
						end
						OP_READ: begin
							if (index >= count_q) begin
								res_status_d = ST_BAD_INDEX;
							end else begin
								re = 1'b1;
								mem_ra = index[AW-1:0];
								done_d = 1'b0;
								state_d = S_RDWAIT;
							end
						end
						OP_WRITE: begin
							if (index >= count_q) begin
								res_status_d = ST_BAD_INDEX;
							end else begin
								we = 1'b1;
								mem_wa = index[AW-1:0];
							end
						end
						OP_INSERT: begin
							if (index > count_q) begin
								res_status_d = ST_BAD_INDEX;
							end else if (count_q >= lim) begin
								res_status_d = ST_FULL;
							end else begin
								count_d = count_q + CW'(1);
								if (index == count_q) begin
									we = 1'b1;
									mem_wa = index[AW-1:0];
								end else begin
									re = 1'b1;
									mem_ra = cnt_m1[AW-1:0];
									ptr_d = cnt_m2[AW-1:0];
									wa_d = count_q[AW-1:0];
									n_d = ins_n[AW-1:0];
									up_d = 1'b1;
									done_d = 1'b0;
									state_d = S_SHIFT;
								end
							end
						end
						OP_ERASE: begin
							if (index >= count_q) begin
								res_status_d = ST_BAD_INDEX;
							end else begin
								count_d = cnt_m1;
								if (idx_p1 < count_q) begin
									re = 1'b1;
									mem_ra = idx_p1[AW-1:0];
									ptr_d = idx_p2[AW-1:0];
									wa_d = index[AW-1:0];
									n_d = ers_n[AW-1:0];
									up_d = 1'b0;
									done_d = 1'b0;
									state_d = S_SHIFT;
								end
							end
						end
						default: begin
							res_status_d = ST_OK;
						end
					endcase
				end
			end
			S_SHIFT: begin
				we = 1'b1;
				mem_wa = wa_q;
				mem_wd = rdata_q;
				wa_d = up_q ? wa_q - AW'(1) : wa_q + AW'(1);
				if (n_q != '0) begin
					re = 1'b1;
					mem_ra = ptr_q;
					ptr_d = up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
					n_d = n_q - AW'(1);
				end else begin
					state_d = S_FINAL;
				end
			end
			S_RDWAIT: begin
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			S_FINAL: begin
				if (up_q) begin
					we = 1'b1;
					mem_wa = idx_q;
					mem_wd = val_q;
				end
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cap_q <= CAP_RESET;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q <= done_d;
			if (cfg_we) begin
				cap_q <= pwdata[6:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		wa_q <= wa_d;
		n_q <= n_d;
		up_q <= up_d;
		if (load) begin
			idx_q <= index[AW-1:0];
			val_q <= write_value;
			res_status_q <= res_status_d;
			res_rd_q <= '0;
			res_count_q <= count_d;
			res_empty_q <= (count_d == '0);
			res_full_q <= (count_d >= lim);
		end else if (state_q == S_RDWAIT) begin
			res_rd_q <= rdata_q;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = res_status_q;
	assign read_value = res_rd_q;
	assign count = 7'(res_count_q);
	assign is_empty = res_empty_q;
	assign is_full = res_full_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ? {25'd0, cap_q} : 32'd0;

endmodule

>>> sv/iaie_checker.sv
module iaie_checker
	import iaie_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         opcode,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [31:0] read_value,
	input logic [6:0]         count,
	input logic               is_empty
);

	// Push, pop, write and unused opcodes never need the memory read path.
	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (opcode == OP_PUSH || opcode == OP_POP ||
		opcode == OP_WRITE || opcode > OP_ERASE)) |=> (done && !busy))
		else $error("short request did not finish in one cycle");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (count == 7'd0)))
		else $error("empty flag disagrees with count");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == 32'sd0))
		else $error("failed request returned data");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (count == 7'd0))
		else $error("empty status with elements stored");

endmodule

bind indexed_array_insert_erase_top iaie_checker u_iaie_checker (.*);
